@@ rtl/core/assert_macros.svh @@
// Assertion macros shared by the framed key block receiver RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on clk and disabled during rst.
`define FKBR_ASSERT_SAME(name, pre, post) \
  name: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
    else $error("receiver check failed in the same cycle");

// Next-cycle implication, sampled on clk and disabled during rst.
`define FKBR_ASSERT_NEXT(name, pre, post) \
  name: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
    else $error("receiver check failed one cycle later");

`endif

@@ rtl/core/fkbr_pkg.sv @@
// Shared commands and result type of the framed key block receiver.
package fkbr_pkg;

  // Command codes carried by each input beat.
  localparam logic [1:0] CMD_BYTE    = 2'd0;
  localparam logic [1:0] CMD_RELEASE = 2'd1;
  localparam logic [1:0] CMD_READ    = 2'd2;
  localparam logic [1:0] CMD_CLEAR   = 2'd3;

  // One result beat.
  typedef struct packed {
    logic [7:0] read_byte;
    logic       read_ok;
    logic       keys_ready;
    logic [6:0] keys_count;
    logic [7:0] message_length;
    logic       receiving;
  } result_t;

endpackage

@@ rtl/core/fkbr_ctrl.sv @@
// Frame state machine, header capture and key store addressing.
module fkbr_ctrl import fkbr_pkg::*; #(
  parameter int MAX_BLOCKS = 64,
  parameter int KEY_BYTES  = 16,
  localparam int DEPTH     = MAX_BLOCKS * KEY_BYTES,
  localparam int ADDR_W    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              accept,
  input  logic [1:0]        command,
  input  logic [7:0]        data_byte,
  input  logic [5:0]        read_block,
  input  logic [3:0]        read_offset,
  output logic              wr_en,
  output logic [ADDR_W-1:0] wr_addr,
  output logic [7:0]        wr_data,
  output logic              rd_en,
  output logic [ADDR_W-1:0] rd_addr,
  output result_t           info
);

  localparam int BYTE_W = (KEY_BYTES > 1) ? $clog2(KEY_BYTES) : 1;
  localparam int BLK_W  = $clog2(MAX_BLOCKS + 1);
  localparam int CMP_W  = (BLK_W > 6) ? BLK_W : 6;
  localparam int MUL_W  = ADDR_W + 7;

  localparam logic [1:0] PH_IDLE     = 2'd0;
  localparam logic [1:0] PH_HEADER   = 2'd1;
  localparam logic [1:0] PH_KEYS     = 2'd2;
  localparam logic [1:0] PH_COMPLETE = 2'd3;

  logic [1:0]        phase, phase_next;
  logic [BYTE_W-1:0] byte_position, byte_position_next;
  logic [BLK_W-1:0]  block_position, block_position_next;
  logic [BLK_W-1:0]  blocks_expected, blocks_expected_next;
  logic [7:0]        length_byte, length_byte_next;
  logic [7:0]        header_first, header_first_next;
  logic              complete_flag, complete_flag_next;
  logic [BLK_W-1:0]  count_done, count_done_next;

  logic [BYTE_W:0]   byte_inc;
  logic [BLK_W-1:0]  block_inc;
  logic [BLK_W-1:0]  count_clamped;
  logic [MUL_W-1:0]  wr_index;
  logic [MUL_W-1:0]  rd_index;
  logic              key_write;
  logic              read_ok;

  assign byte_inc  = {1'b0, byte_position} + (BYTE_W + 1)'(1);
  assign block_inc = block_position + BLK_W'(1);
  assign count_clamped = (9'(data_byte) > 9'(MAX_BLOCKS)) ? BLK_W'(MAX_BLOCKS)
                                                           : BLK_W'(data_byte);

  // Store addresses: block times key size plus byte offset.
  assign wr_index = MUL_W'(block_position) * MUL_W'(KEY_BYTES) + MUL_W'(byte_position);
  assign rd_index = MUL_W'(read_block) * MUL_W'(KEY_BYTES) + MUL_W'(read_offset);
  assign wr_addr  = wr_index[ADDR_W-1:0];
  assign rd_addr  = rd_index[ADDR_W-1:0];
  assign wr_data  = data_byte;

  // A key byte is stored only while announced blocks remain.
  assign key_write = (command == CMD_BYTE) && (phase == PH_KEYS) &&
                     (block_position < blocks_expected);
  assign wr_en = accept && key_write;

  // A read succeeds only on a complete frame and within the announced blocks.
  assign read_ok = (command == CMD_READ) && complete_flag &&
                   (CMP_W'(read_block) < CMP_W'(blocks_expected)) &&
                   (7'(read_offset) < 7'(KEY_BYTES));
  assign rd_en = accept && read_ok;

  // Next state for the accepted beat.
  always_comb begin
    phase_next           = phase;
    byte_position_next   = byte_position;
    block_position_next  = block_position;
    blocks_expected_next = blocks_expected;
    length_byte_next     = length_byte;
    header_first_next    = header_first;
    complete_flag_next   = complete_flag;
    count_done_next      = count_done;
    case (command)
      CMD_BYTE: begin
        if (phase == PH_IDLE || phase == PH_HEADER) begin
          if (phase == PH_IDLE || byte_position == '0) begin
            // First header byte; a frame start also rewinds the positions.
            phase_next          = PH_HEADER;
            header_first_next   = data_byte;
            byte_position_next  = BYTE_W'(1);
            block_position_next = '0;
          end else begin
            phase_next           = PH_KEYS;
            length_byte_next     = header_first;
            blocks_expected_next = count_clamped;
            byte_position_next   = '0;
            block_position_next  = '0;
          end
        end else if (key_write) begin
          if (byte_inc >= (BYTE_W + 1)'(KEY_BYTES)) begin
            byte_position_next  = '0;
            block_position_next = block_inc;
            count_done_next     = block_inc;
            if (block_inc >= blocks_expected) begin
              phase_next         = PH_COMPLETE;
              complete_flag_next = 1'b1;
            end
          end else begin
            byte_position_next = byte_inc[BYTE_W-1:0];
          end
        end
      end
      CMD_RELEASE: begin
        if (phase != PH_COMPLETE) begin
          phase_next = PH_IDLE;
        end
      end
      CMD_READ: begin
        phase_next = phase;
      end
      default: begin
        phase_next           = PH_IDLE;
        byte_position_next   = '0;
        block_position_next  = '0;
        blocks_expected_next = '0;
        length_byte_next     = '0;
        header_first_next    = '0;
        complete_flag_next   = 1'b0;
        count_done_next      = '0;
      end
    endcase
  end

  // Frame state registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      phase           <= PH_IDLE;
      byte_position   <= '0;
      block_position  <= '0;
      blocks_expected <= '0;
      length_byte     <= '0;
      header_first    <= '0;
      complete_flag   <= 1'b0;
      count_done      <= '0;
    end else if (accept) begin
      phase           <= phase_next;
      byte_position   <= byte_position_next;
      block_position  <= block_position_next;
      blocks_expected <= blocks_expected_next;
      length_byte     <= length_byte_next;
      header_first    <= header_first_next;
      complete_flag   <= complete_flag_next;
      count_done      <= count_done_next;
    end
  end

  // Result fields after the update; the key byte joins them in the result stage from the store read port.
  always_ff @(posedge clk) begin
    if (accept) begin
      info.read_byte      <= 8'd0;
      info.read_ok        <= read_ok;
      info.keys_ready     <= complete_flag_next;
      info.keys_count     <= 7'(count_done_next);
      info.message_length <= length_byte_next;
      info.receiving      <= (command == CMD_BYTE);
    end
  end

endmodule

@@ rtl/core/fkbr_store.sv @@
// Key byte memory with one write port and one registered read port.
module fkbr_store #(
  parameter int DEPTH    = 1024,
  localparam int ADDR_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic [7:0]        wr_data,
  input  logic              rd_en,
  input  logic [ADDR_W-1:0] rd_addr,
  output logic [7:0]        rd_data
);

  logic [7:0] mem [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Read port; the data holds until the next read.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

@@ rtl/core/fkbr_outq.sv @@
// Two-entry result queue between the result stage and the output port.
module fkbr_outq import fkbr_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    push,
  input  result_t push_data,
  output logic    space,
  output logic    result_valid,
  input  logic    result_ready,
  output result_t head
);

  result_t    entries [2];
  logic [1:0] count;
  logic       wr_ptr;
  logic       rd_ptr;
  logic       pop;

  assign space        = (count != 2'd2);
  assign result_valid = (count != 2'd0);
  assign pop          = result_valid && result_ready;
  assign head         = entries[rd_ptr];

  // Entry storage.
  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_data;
    end
  end

  // Pointers and fill level.
  always_ff @(posedge clk) begin
    if (rst) begin
      count  <= 2'd0;
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      if (push && !pop) begin
        count <= count + 2'd1;
      end else if (pop && !push) begin
        count <= count - 2'd1;
      end
    end
  end

endmodule

@@ rtl/core/framed_key_block_receiver_top.sv @@
// Framed key block receiver: header capture, key storage and key byte reads.
// A result passes the result stage and then the queue before it can be taken at the output.
// One beat per cycle while the queue has room; frame state and store write take effect on accept.
// The result stage and a two-entry queue let input beats flow while a result waits.
// Reset clears the frame state and the queue; key store contents stay undefined.
// A store entry is only readable after the current frame has written it.
`include "assert_macros.svh"

module framed_key_block_receiver_top import fkbr_pkg::*; #(
  parameter int MAX_BLOCKS = 64,
  parameter int KEY_BYTES  = 16
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       item_valid,
  output logic       item_ready,
  input  logic [1:0] command,
  input  logic [7:0] data_byte,
  input  logic [5:0] read_block,
  input  logic [3:0] read_offset,
  output logic       result_valid,
  input  logic       result_ready,
  output logic [7:0] read_byte,
  output logic       read_ok,
  output logic       keys_ready,
  output logic [6:0] keys_count,
  output logic [7:0] message_length,
  output logic       receiving
);

  localparam int DEPTH  = MAX_BLOCKS * KEY_BYTES;
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic              accept;
  logic              wr_en;
  logic [ADDR_W-1:0] wr_addr;
  logic [7:0]        wr_data;
  logic              rd_en;
  logic [ADDR_W-1:0] rd_addr;
  logic [7:0]        rd_data;
  result_t           info;
  result_t           s1_data;
  logic              s1_valid;
  logic              q_space;
  logic              push;
  result_t           head;

  // The result stage moves on whenever the queue has room.
  assign push       = s1_valid && q_space;
  assign item_ready = !s1_valid || q_space;
  assign accept     = item_valid && item_ready;

  fkbr_ctrl #(
    .MAX_BLOCKS (MAX_BLOCKS),
    .KEY_BYTES  (KEY_BYTES)
  ) u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .accept      (accept),
    .command     (command),
    .data_byte   (data_byte),
    .read_block  (read_block),
    .read_offset (read_offset),
    .wr_en       (wr_en),
    .wr_addr     (wr_addr),
    .wr_data     (wr_data),
    .rd_en       (rd_en),
    .rd_addr     (rd_addr),
    .info        (info)
  );

  fkbr_store #(
    .DEPTH (DEPTH)
  ) u_store (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // Result stage: the frame fields plus the key byte for a good read.
  always_comb begin
    s1_data           = info;
    s1_data.read_byte = info.read_ok ? rd_data : 8'd0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (accept) begin
      s1_valid <= 1'b1;
    end else if (push) begin
      s1_valid <= 1'b0;
    end
  end

  fkbr_outq u_outq (
    .clk          (clk),
    .rst          (rst),
    .push         (push),
    .push_data    (s1_data),
    .space        (q_space),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .head         (head)
  );

  assign read_byte      = head.read_byte;
  assign read_ok        = head.read_ok;
  assign keys_ready     = head.keys_ready;
  assign keys_count     = head.keys_count;
  assign message_length = head.message_length;
  assign receiving      = head.receiving;

  // Checks on the result stage and the result fields.
  `FKBR_ASSERT_SAME(a_read_needs_ready, result_valid && read_ok, keys_ready)
  `FKBR_ASSERT_SAME(a_failed_read_zero, result_valid && !read_ok, read_byte == 8'd0)
  `FKBR_ASSERT_NEXT(a_accept_fills_stage, accept, s1_valid)
  `FKBR_ASSERT_NEXT(a_stalled_stage_holds, s1_valid && !q_space, s1_valid && $stable(s1_data))

endmodule
